// ===== rtl/tle_pkg.sv =====
// Shared types, codes and constants for the console line editor.
package tle_pkg;

  // Width of the character count and of the delivered count field.
  localparam int CNT_W = 5;
  // Default depth of the line store.
  localparam int LINE_MAX_DEF = 16;

  // Control characters.
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_KILL = 8'h15;
  localparam logic [7:0] CH_SP   = 8'h20;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_CANON = 2'd0;
  localparam logic [1:0] REG_ECHO  = 2'd1;
  localparam logic [1:0] REG_LEN   = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ER_BS1,
    S_ER_SP,
    S_ER_BS2,
    S_ECHO,
    S_RD,
    S_BYTE,
    S_CNT
  } state_t;

  // Class of an incoming input beat.
  typedef enum logic [1:0] {
    CLS_EOI,
    CLS_BS,
    CLS_KILL,
    CLS_STORE
  } in_cls_t;

  // Source of an emitted result.
  typedef enum logic [2:0] {
    SRC_BS,
    SRC_SP,
    SRC_CHAR,
    SRC_BYTE,
    SRC_COUNT
  } src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic store;
    logic cnt_dec;
    logic cnt_clr;
    logic mem_rd;
    logic idx_inc;
    logic emit;
    src_t src;
    logic last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    in_cls_t cls;
    logic    echo_en;
    logic    deliver_now;
    logic    count_zero;
    logic    count_one;
    logic    idx_last;
    logic    out_free;
  } dp_stat_t;

endpackage

// ===== rtl/tle_dp.sv =====
// Datapath of the line editor: registers, line store, count and output register.
module tle_dp #(
  parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [4:0]             cfg_wdata,
  input  logic [7:0]             in_char_in,
  input  logic                   in_end_of_input,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [1:0]             out_result_kind,
  output logic [7:0]             out_byte_out,
  output logic [4:0]             out_read_count,
  output logic                   out_run_last,
  input  tle_pkg::ctrl_cmd_t     cmd,
  output tle_pkg::dp_stat_t      stat
);
  import tle_pkg::*;

  localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam logic [CNT_W-1:0] LMAX = CNT_W'(LINE_MAX);

  logic             canon_r, echo_r;
  logic [4:0]       req_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       char_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       mem [LINE_MAX];

  logic             out_valid_r;
  logic [1:0]       kind_r;
  logic [7:0]       byte_r;
  logic [CNT_W-1:0] rcnt_r;
  logic             last_r;

  logic [7:0]       mapped;
  logic [CNT_W-1:0] cnt_after, eff_len;
  logic             room;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canon_r <= 1'b1;
      echo_r  <= 1'b1;
      req_r   <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CANON: canon_r <= cfg_wdata[0];
        REG_ECHO:  echo_r  <= cfg_wdata[0];
        REG_LEN:   req_r   <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Decode the incoming character and work out whether it completes the line.
  always_comb begin
    mapped = (canon_r && in_char_in == CH_CR) ? CH_LF : in_char_in;
    room   = (cnt_r < LMAX);
    cnt_after = room ? cnt_r + CNT_W'(1) : cnt_r;
    if (req_r == 5'd0) eff_len = CNT_W'(1);
    else if (req_r > LMAX) eff_len = LMAX;
    else eff_len = req_r;

    if (in_end_of_input) stat.cls = CLS_EOI;
    else if (canon_r && in_char_in == CH_BS) stat.cls = CLS_BS;
    else if (canon_r && in_char_in == CH_KILL) stat.cls = CLS_KILL;
    else stat.cls = CLS_STORE;

    stat.echo_en     = echo_r;
    stat.deliver_now = (canon_r && mapped == CH_LF) || (cnt_after >= eff_len);
    stat.count_zero  = (cnt_r == '0);
    stat.count_one   = (cnt_r == CNT_W'(1));
    stat.idx_last    = (CNT_W'(idx_r) + CNT_W'(1) == cnt_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  // Character count.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) cnt_nxt = '0;
    else if (cmd.store) cnt_nxt = cnt_after;
    else if (cmd.cnt_dec) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  // Latched character and delivery index.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_r <= mapped;
      idx_r  <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // Line store: one write at accept, one registered read during delivery.
  always_ff @(posedge clk) begin
    if (cmd.store && room) mem[cnt_r[IDX_W-1:0]] <= mapped;
    if (cmd.mem_rd) rd_data_r <= mem[idx_r];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_r <= cmd.last;
      rcnt_r <= '0;
      case (cmd.src)
        SRC_BS:    begin kind_r <= KIND_ECHO;  byte_r <= CH_BS;     end
        SRC_SP:    begin kind_r <= KIND_ECHO;  byte_r <= CH_SP;     end
        SRC_CHAR:  begin kind_r <= KIND_ECHO;  byte_r <= char_r;    end
        SRC_BYTE:  begin kind_r <= KIND_BYTE;  byte_r <= rd_data_r; end
        default: begin
          kind_r <= KIND_COUNT;
          byte_r <= 8'd0;
          rcnt_r <= cnt_r;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_byte_out    = byte_r;
  assign out_read_count  = rcnt_r;
  assign out_run_last    = last_r;

endmodule

// ===== rtl/tle_ctrl.sv =====
// Controller state machine of the line editor.
module tle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tle_pkg::dp_stat_t  stat,
  output tle_pkg::ctrl_cmd_t cmd
);
  import tle_pkg::*;

  state_t state_r, state_nxt;
  logic   kill_r, kill_nxt;
  logic   dlv_r, dlv_nxt;

  // State and mode flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kill_r  <= 1'b0;
      dlv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kill_r  <= kill_nxt;
      dlv_r   <= dlv_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    kill_nxt  = kill_r;
    dlv_nxt   = dlv_r;
    cmd       = '0;
    cmd.src   = SRC_BS;
    in_ready  = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (stat.cls)
            CLS_EOI: state_nxt = S_RD;
            CLS_BS: begin
              if (!stat.count_zero) begin
                if (stat.echo_en) begin
                  kill_nxt  = 1'b0;
                  state_nxt = S_ER_BS1;
                end else begin
                  cmd.cnt_dec = 1'b1;
                end
              end
            end
            CLS_KILL: begin
              if (!stat.count_zero) begin
                if (stat.echo_en) begin
                  kill_nxt  = 1'b1;
                  state_nxt = S_ER_BS1;
                end else begin
                  cmd.cnt_clr = 1'b1;
                end
              end
            end
            default: begin
              cmd.store = 1'b1;
              dlv_nxt   = stat.deliver_now;
              if (stat.echo_en) state_nxt = S_ECHO;
              else if (stat.deliver_now) state_nxt = S_RD;
            end
          endcase
        end
      end
      // Erase triple: backspace, space, backspace.
      S_ER_BS1: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_BS;
          state_nxt = S_ER_SP;
        end
      end
      S_ER_SP: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_SP;
          state_nxt = S_ER_BS2;
        end
      end
      S_ER_BS2: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_BS;
          cmd.cnt_dec = 1'b1;
          cmd.last    = !kill_r || stat.count_one;
          state_nxt   = (kill_r && !stat.count_one) ? S_ER_BS1 : S_IDLE;
        end
      end
      // Echo of a stored character.
      S_ECHO: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_CHAR;
          cmd.last  = !dlv_r;
          state_nxt = dlv_r ? S_RD : S_IDLE;
        end
      end
      // Delivery: read one stored byte, then send it.
      S_RD: begin
        if (stat.count_zero) begin
          state_nxt = S_CNT;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_BYTE;
        end
      end
      S_BYTE: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_BYTE;
          cmd.idx_inc = 1'b1;
          state_nxt   = stat.idx_last ? S_CNT : S_RD;
        end
      end
      S_CNT: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_COUNT;
          cmd.last    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/tty_line_editor.sv =====
// Top level of the console line editor.
// Takes one console character per input beat and sends its results one beat per cycle at
// most through a registered output. An input beat is taken only when the previous one has
// finished. With echo on, a stored character is followed by its echo, and each character
// erased by a backspace or a kill by the echo bytes backspace, space, backspace. A line
// delivery reads each stored byte from the registered line store and then sends it,
// followed by the count; an empty line sends only the count. With the default depth the
// longest kill erases 15 characters, and output stalls hold up any of these steps.
// Configuration may only be written while no beat is in progress.
module tty_line_editor #(
  parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_byte_out,
  output logic [4:0] out_read_count,
  output logic       out_run_last
);
  import tle_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencing.
  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result formation.
  tle_dp #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_char_in      (in_char_in),
    .in_end_of_input (in_end_of_input),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_byte_out    (out_byte_out),
    .out_read_count  (out_read_count),
    .out_run_last    (out_run_last),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
